/* rtl/core/sme_pkg.sv */
// Shared types, op codes, status codes and sizes for the stack machine executor.
package sme_pkg;

   localparam int SME_STACK_DEPTH = 64;
   localparam int SME_WORD_W      = 32;
   localparam int SME_OP_W        = 4;
   localparam int SME_STATUS_W    = 3;

   localparam logic [SME_WORD_W-1:0] SME_CHAR_MAX = 32'd255;

   // Instruction codes.
   localparam logic [SME_OP_W-1:0] OP_PUSH     = 4'd0;
   localparam logic [SME_OP_W-1:0] OP_POP      = 4'd1;
   localparam logic [SME_OP_W-1:0] OP_SWAP     = 4'd2;
   localparam logic [SME_OP_W-1:0] OP_ADD      = 4'd3;
   localparam logic [SME_OP_W-1:0] OP_SUB      = 4'd4;
   localparam logic [SME_OP_W-1:0] OP_MUL      = 4'd5;
   localparam logic [SME_OP_W-1:0] OP_DIV      = 4'd6;
   localparam logic [SME_OP_W-1:0] OP_MOD      = 4'd7;
   localparam logic [SME_OP_W-1:0] OP_PINT     = 4'd8;
   localparam logic [SME_OP_W-1:0] OP_PALL     = 4'd9;
   localparam logic [SME_OP_W-1:0] OP_PUT_CHAR = 4'd10;
   localparam logic [SME_OP_W-1:0] OP_NOP      = 4'd11;

   // Result status codes.
   localparam logic [SME_STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [SME_STATUS_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [SME_STATUS_W-1:0] ST_SHORT   = 3'd2;
   localparam logic [SME_STATUS_W-1:0] ST_DIVZERO = 3'd3;
   localparam logic [SME_STATUS_W-1:0] ST_CHAR    = 3'd4;
   localparam logic [SME_STATUS_W-1:0] ST_FULL    = 3'd5;

   // Operations of the shared arithmetic unit.
   typedef logic [2:0] alu_kind_type;
   localparam alu_kind_type ALU_ADD = 3'd0;
   localparam alu_kind_type ALU_SUB = 3'd1;
   localparam alu_kind_type ALU_MUL = 3'd2;
   localparam alu_kind_type ALU_DIV = 3'd3;
   localparam alu_kind_type ALU_MOD = 3'd4;

   typedef struct packed {
      logic         start;
      alu_kind_type kind;
   } alu_ctl_type;

endpackage

/* rtl/core/sme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sme_alu.sv */
// Shared arithmetic unit: add, sub and mul done in the cycle after start, bit-serial signed div and mod.
module sme_alu
   import sme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  alu_ctl_type           ctl,
   input  logic [SME_WORD_W-1:0] a_val,
   input  logic [SME_WORD_W-1:0] b_val,
   output logic                  done,
   output logic [SME_WORD_W-1:0] result
);

   localparam int STEP_W = $clog2(SME_WORD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SME_WORD_W - 1);

   logic                  busy_ff, busy_in;
   logic                  fix_ff, fix_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SME_WORD_W:0]   rem_ff, rem_in;
   logic [SME_WORD_W-1:0] quo_ff, quo_in;
   logic [SME_WORD_W-1:0] dvs_ff, dvs_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;
   logic                  is_mod_ff, is_mod_in;
   logic [SME_WORD_W-1:0] result_ff, result_in;

   logic [SME_WORD_W:0]   rem_shift;
   logic [SME_WORD_W:0]   rem_diff;

   always_comb begin
      busy_in   = busy_ff;
      fix_in    = fix_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      is_mod_in = is_mod_ff;
      result_in = result_ff;

      // One restoring division step: shift in the next dividend bit and try a subtract.
      rem_shift = {rem_ff[SME_WORD_W-1:0], quo_ff[SME_WORD_W-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};

      if (ctl.start) begin
         case (ctl.kind)
            ALU_ADD: begin
               result_in = a_val + b_val;
               done_in   = 1'b1;
            end
            ALU_SUB: begin
               result_in = a_val - b_val;
               done_in   = 1'b1;
            end
            ALU_MUL: begin
               result_in = a_val * b_val;
               done_in   = 1'b1;
            end
            default: begin
               // Divide magnitudes and fix the signs at the end.
               neg_q_in  = a_val[SME_WORD_W-1] ^ b_val[SME_WORD_W-1];
               neg_r_in  = a_val[SME_WORD_W-1];
               is_mod_in = (ctl.kind == ALU_MOD);
               quo_in    = a_val[SME_WORD_W-1] ? (~a_val + 1'b1) : a_val;
               dvs_in    = b_val[SME_WORD_W-1] ? (~b_val + 1'b1) : b_val;
               rem_in    = '0;
               step_in   = '0;
               busy_in   = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (!rem_diff[SME_WORD_W]) begin
            rem_in = rem_diff;
            quo_in = {quo_ff[SME_WORD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[SME_WORD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         if (is_mod_ff) begin
            result_in = neg_r_ff ? (~rem_ff[SME_WORD_W-1:0] + 1'b1) : rem_ff[SME_WORD_W-1:0];
         end else begin
            result_in = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
         end
         fix_in  = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      is_mod_ff <= is_mod_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* rtl/core/stack_machine_executor_unit.sv */
// Top level of the stack machine executor: sequencer, stack memory and shared arithmetic unit.
//
// The block executes one stack instruction per request transfer on a stack of up to
// STACK_DEPTH signed 32-bit words held in a single-port-read RAM, and takes one request at a
// time: req_ready is high only while the sequencer is idle. Every stack read goes through the
// RAM's one registered read port, so top and second are fetched on successive cycles, and all
// arithmetic runs through one shared unit. Pint and pchar end with the output transfer; div
// and mod run through the bit-serial divider that retires one quotient bit per cycle. Pall
// does one read and one result transfer per entry, from top to bottom, with rsp_last set on
// the bottom entry. Any failing instruction leaves the stack untouched and produces exactly
// one result transfer with value zero, the error status and rsp_last set. Results sit in an
// output register, so a new request can be taken while the previous result still waits for
// rsp_ready.
module stack_machine_executor_unit
   import sme_pkg::*;
#(
   parameter int STACK_DEPTH = SME_STACK_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [SME_OP_W-1:0]            req_op,
   input  logic signed [SME_WORD_W-1:0]   req_operand,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SME_WORD_W-1:0]   rsp_value,
   output logic [SME_STATUS_W-1:0]        rsp_status,
   output logic                           rsp_last
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_RD_TOP   = 4'd2;
   localparam logic [3:0] S_GOT_TOP  = 4'd3;
   localparam logic [3:0] S_GOT_SEC  = 4'd4;
   localparam logic [3:0] S_EXEC     = 4'd5;
   localparam logic [3:0] S_SWAP2    = 4'd6;
   localparam logic [3:0] S_ALU_WAIT = 4'd7;
   localparam logic [3:0] S_PALL_RD  = 4'd8;
   localparam logic [3:0] S_PALL_GOT = 4'd9;
   localparam logic [3:0] S_EMIT     = 4'd10;

   logic [3:0]              state_ff, state_in;
   logic [SME_OP_W-1:0]     op_ff, op_in;
   logic [SME_WORD_W-1:0]   operand_ff, operand_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SME_WORD_W-1:0]   top_ff, top_in;
   logic [SME_WORD_W-1:0]   second_ff, second_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic                    pall_ff, pall_in;
   logic [SME_WORD_W-1:0]   emit_value_ff, emit_value_in;
   logic [SME_STATUS_W-1:0] emit_status_ff, emit_status_in;
   logic                    emit_last_ff, emit_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SME_WORD_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [SME_STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Stack memory port signals.
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SME_WORD_W-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SME_WORD_W-1:0] rd_data;

   // Arithmetic unit signals.
   alu_ctl_type           alu_ctl;
   logic                  alu_done;
   logic [SME_WORD_W-1:0] alu_result;

   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W-1:0]  cnt_m2;
   logic [ADDR_W-1:0] addr_top;
   logic [ADDR_W-1:0] addr_sec;
   logic [ADDR_W-1:0] addr_push;
   logic              out_free;

   assign cnt_m1    = count_ff - CNT_ONE;
   assign cnt_m2    = count_ff - CNT_TWO;
   assign addr_top  = cnt_m1[ADDR_W-1:0];
   assign addr_sec  = cnt_m2[ADDR_W-1:0];
   assign addr_push = count_ff[ADDR_W-1:0];

   // The output register can take a new result when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      operand_in     = operand_ff;
      count_in       = count_ff;
      top_in         = top_ff;
      second_in      = second_ff;
      idx_in         = idx_ff;
      pall_in        = pall_ff;
      emit_value_in  = emit_value_ff;
      emit_status_in = emit_status_ff;
      emit_last_in   = emit_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      alu_ctl.start  = 1'b0;
      alu_ctl.kind   = ALU_ADD;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               operand_in = req_operand;
               state_in   = S_DECODE;
            end
         end

         S_DECODE: begin
            // Error results share one shape; only the status differs.
            emit_value_in = '0;
            emit_last_in  = 1'b1;
            pall_in       = 1'b0;
            state_in      = S_IDLE;
            case (op_ff)
               OP_PUSH: begin
                  if (count_ff == CNT_FULL) begin
                     emit_status_in = ST_FULL;
                     state_in       = S_EMIT;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = addr_push;
                     wr_data  = operand_ff;
                     count_in = count_ff + CNT_ONE;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     emit_status_in = ST_EMPTY;
                     state_in       = S_EMIT;
                  end else begin
                     count_in = cnt_m1;
                  end
               end
               OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                  if (count_ff < CNT_TWO) begin
                     emit_status_in = ST_SHORT;
                     state_in       = S_EMIT;
                  end else begin
                     state_in = S_RD_TOP;
                  end
               end
               OP_PINT, OP_PUT_CHAR: begin
                  if (count_ff == '0) begin
                     emit_status_in = ST_EMPTY;
                     state_in       = S_EMIT;
                  end else begin
                     state_in = S_RD_TOP;
                  end
               end
               OP_PALL: begin
                  // An empty stack prints nothing at all.
                  if (count_ff != '0) begin
                     idx_in   = addr_top;
                     state_in = S_PALL_RD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_RD_TOP: begin
            rd_en    = 1'b1;
            rd_addr  = addr_top;
            state_in = S_GOT_TOP;
         end

         S_GOT_TOP: begin
            top_in         = rd_data;
            emit_value_in  = rd_data;
            emit_status_in = ST_OK;
            emit_last_in   = 1'b1;
            pall_in        = 1'b0;
            if (op_ff == OP_PINT) begin
               state_in = S_EMIT;
            end else if (op_ff == OP_PUT_CHAR) begin
               // The range test is unsigned, so negative values fail as well.
               if (rd_data > SME_CHAR_MAX) begin
                  emit_value_in  = '0;
                  emit_status_in = ST_CHAR;
               end
               state_in = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = addr_sec;
               state_in = S_GOT_SEC;
            end
         end

         S_GOT_SEC: begin
            second_in = rd_data;
            state_in  = S_EXEC;
         end

         S_EXEC: begin
            case (op_ff)
               OP_SWAP: begin
                  wr_en    = 1'b1;
                  wr_addr  = addr_top;
                  wr_data  = second_ff;
                  state_in = S_SWAP2;
               end
               OP_ADD: begin
                  alu_ctl.start = 1'b1;
                  alu_ctl.kind  = ALU_ADD;
                  state_in      = S_ALU_WAIT;
               end
               OP_SUB: begin
                  alu_ctl.start = 1'b1;
                  alu_ctl.kind  = ALU_SUB;
                  state_in      = S_ALU_WAIT;
               end
               OP_MUL: begin
                  alu_ctl.start = 1'b1;
                  alu_ctl.kind  = ALU_MUL;
                  state_in      = S_ALU_WAIT;
               end
               OP_DIV, OP_MOD: begin
                  if (top_ff == '0) begin
                     emit_value_in  = '0;
                     emit_status_in = ST_DIVZERO;
                     emit_last_in   = 1'b1;
                     pall_in        = 1'b0;
                     state_in       = S_EMIT;
                  end else begin
                     alu_ctl.start = 1'b1;
                     alu_ctl.kind  = (op_ff == OP_DIV) ? ALU_DIV : ALU_MOD;
                     state_in      = S_ALU_WAIT;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_SWAP2: begin
            wr_en    = 1'b1;
            wr_addr  = addr_sec;
            wr_data  = top_ff;
            state_in = S_IDLE;
         end

         S_ALU_WAIT: begin
            if (alu_done) begin
               wr_en    = 1'b1;
               wr_addr  = addr_sec;
               wr_data  = alu_result;
               count_in = cnt_m1;
               state_in = S_IDLE;
            end
         end

         S_PALL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_PALL_GOT;
         end

         S_PALL_GOT: begin
            emit_value_in  = rd_data;
            emit_status_in = ST_OK;
            emit_last_in   = (idx_ff == '0);
            pall_in        = 1'b1;
            state_in       = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = emit_value_ff;
               rsp_status_in = emit_status_ff;
               rsp_last_in   = emit_last_ff;
               if (pall_ff && (idx_ff != '0)) begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_PALL_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      operand_ff     <= operand_in;
      top_ff         <= top_in;
      second_ff      <= second_in;
      idx_ff         <= idx_in;
      pall_ff        <= pall_in;
      emit_value_ff  <= emit_value_in;
      emit_status_ff <= emit_status_in;
      emit_last_ff   <= emit_last_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   sme_ram #(
      .WIDTH (SME_WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Second element is the left operand, top is the right one.
   sme_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a_val  (second_ff),
      .b_val  (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

/* rtl/core/sme_checker.sv */
// Port-level checker for the stack machine executor and its bind to the top level.
module sme_checker
   import sme_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [SME_WORD_W-1:0] rsp_value,
   input logic [SME_STATUS_W-1:0]      rsp_status,
   input logic                         rsp_last
);

   // A stalled result must hold still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_value) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // An error result carries a zero value and ends its instruction.
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_value == '0) && rsp_last)
      else $error("error result with nonzero value or without last");

   // The block works on one instruction at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an instruction is in progress");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind stack_machine_executor_unit sme_checker u_sme_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

/* verif/tb_stack_machine_executor_unit.sv */
// Self-checking testbench for the stack machine executor: directed, random and backpressure tests.
module tb_stack_machine_executor_unit
   import sme_pkg::*;
();

   // Op codes above nop are not decoded by the block and behave as nop.
   localparam logic [SME_OP_W-1:0] OP_UNUSED_FIRST = 4'd12;
   localparam logic [SME_OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

   localparam logic [SME_WORD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [SME_WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [SME_WORD_W-1:0] WORD_NEG_ONE = 32'hFFFF_FFFF;

   // Div and mod run a bit-serial divider; this settle time covers any
   // instruction still in flight after its last result has left the block.
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [SME_WORD_W-1:0]   value;
      logic [SME_STATUS_W-1:0] status;
      logic                    last;
   } rsp_beat_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [SME_OP_W-1:0]          req_op = OP_NOP;
   logic signed [SME_WORD_W-1:0] req_operand = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [SME_WORD_W-1:0] rsp_value;
   logic [SME_STATUS_W-1:0]      rsp_status;
   logic                         rsp_last;

   // Shadow copy of the stack, updated at each accepted request transfer.
   logic [SME_WORD_W-1:0] shadow_stack [SME_STACK_DEPTH];
   int unsigned           stack_len = 0;
   rsp_beat_type          expected_beats [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   int hold_req_id = 0;
   int hold_ack_id = 0;
   int unsigned gen_depth = 0;

   stack_machine_executor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void expect_beat(input logic [SME_WORD_W-1:0] value,
                                       input logic [SME_STATUS_W-1:0] status,
                                       input logic last);
      rsp_beat_type beat;
      beat.value  = value;
      beat.status = status;
      beat.last   = last;
      expected_beats.push_back(beat);
   endfunction

   // Executes one instruction on the shadow stack and queues the results that
   // the block must produce for it. A failing instruction leaves the stack
   // as it was and yields a single zero-valued result carrying the status.
   function automatic void execute_instr(input logic [SME_OP_W-1:0] op,
                                         input logic [SME_WORD_W-1:0] operand);
      logic signed [SME_WORD_W-1:0] top;
      logic signed [SME_WORD_W-1:0] second;
      logic signed [SME_WORD_W-1:0] res;
      int idx;
      top = '0;
      second = '0;
      res = '0;
      if (stack_len >= 2) begin
         top    = shadow_stack[stack_len-1];
         second = shadow_stack[stack_len-2];
      end
      case (op)
         OP_PUSH: begin
            if (stack_len >= SME_STACK_DEPTH) begin
               expect_beat('0, ST_FULL, 1'b1);
            end else begin
               shadow_stack[stack_len] = operand;
               stack_len++;
            end
         end
         OP_POP: begin
            if (stack_len == 0) expect_beat('0, ST_EMPTY, 1'b1);
            else stack_len--;
         end
         OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            if (stack_len < 2) begin
               expect_beat('0, ST_SHORT, 1'b1);
            end else if (op == OP_SWAP) begin
               shadow_stack[stack_len-1] = second;
               shadow_stack[stack_len-2] = top;
            end else if ((op == OP_DIV || op == OP_MOD) && top == 0) begin
               expect_beat('0, ST_DIVZERO, 1'b1);
            end else begin
               // Second is the left operand, top the right one. The most
               // negative value over minus one wraps to itself with no remainder.
               case (op)
                  OP_ADD: res = second + top;
                  OP_SUB: res = second - top;
                  OP_MUL: res = second * top;
                  OP_DIV: begin
                     if (second == WORD_MIN && top == WORD_NEG_ONE) res = WORD_MIN;
                     else res = second / top;
                  end
                  default: begin
                     if (top == WORD_NEG_ONE) res = '0;
                     else res = second % top;
                  end
               endcase
               shadow_stack[stack_len-2] = res;
               stack_len--;
            end
         end
         OP_PINT: begin
            if (stack_len == 0) expect_beat('0, ST_EMPTY, 1'b1);
            else expect_beat(shadow_stack[stack_len-1], ST_OK, 1'b1);
         end
         OP_PALL: begin
            for (idx = int'(stack_len) - 1; idx >= 0; idx--)
               expect_beat(shadow_stack[idx], ST_OK, idx == 0);
         end
         OP_PUT_CHAR: begin
            if (stack_len == 0) expect_beat('0, ST_EMPTY, 1'b1);
            else if (shadow_stack[stack_len-1] > SME_CHAR_MAX) expect_beat('0, ST_CHAR, 1'b1);
            else expect_beat(shadow_stack[stack_len-1], ST_OK, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Result checking comes before prediction at each edge: a result that
   // leaves at the same edge as a request transfer belongs to an older one.
   always @(posedge clock) begin : check_proc
      rsp_beat_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result: value %0d status %0d last %0b",
                      rsp_value, rsp_status, rsp_last);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_value !== want.value) begin
                  $error("rsp_value: expected %0d, actual %0d", $signed(want.value), rsp_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last: expected %0b, actual %0b", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) execute_instr(req_op, req_operand);
      end
   end

   // Receiver side: a long hold-off, when requested, overrides random stalls.
   always @(posedge clock) begin
      if (hold_req_id != hold_ack_id) begin
         hold_ack_id <= hold_req_id;
         hold_left   <= LONG_HOLD_CYCLES - 1;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offers one instruction and returns at the edge where it is transferred.
   // Valid stays high on return so that a following call can keep it high.
   task automatic send_instr(input logic [SME_OP_W-1:0] op,
                             input logic [SME_WORD_W-1:0] operand);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_operand <= operand;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SME_WORD_W-1:0] pick_operand();
      case ($urandom_range(7))
         0: return '0;
         1: return WORD_NEG_ONE;
         2: return $urandom_range(300);
         3: return -$urandom_range(20, 1);
         4: return WORD_MIN;
         5: return WORD_MAX;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [SME_OP_W-1:0] pick_op(input int unsigned depth);
      int unsigned roll;
      roll = $urandom_range(99);
      if (depth < 2 && roll < 60) return OP_PUSH;
      roll = $urandom_range(99);
      if (roll < 28) return OP_PUSH;
      if (roll < 36) return OP_POP;
      if (roll < 42) return OP_SWAP;
      if (roll < 49) return OP_ADD;
      if (roll < 55) return OP_SUB;
      if (roll < 61) return OP_MUL;
      if (roll < 69) return OP_DIV;
      if (roll < 77) return OP_MOD;
      if (roll < 84) return OP_PINT;
      if (roll < 88) return OP_PALL;
      if (roll < 95) return OP_PUT_CHAR;
      if (roll < 97) return OP_NOP;
      return SME_OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
   endfunction

   // Rough depth estimate for shaping stimulus; a division by zero makes it drift.
   function automatic void note_depth(input logic [SME_OP_W-1:0] op);
      if (op == OP_PUSH && gen_depth < SME_STACK_DEPTH) gen_depth++;
      else if (op == OP_POP && gen_depth > 0) gen_depth--;
      else if (op >= OP_ADD && op <= OP_MOD && gen_depth >= 2) gen_depth--;
   endfunction

   // The empty, short, divide-by-zero and character error statuses, the empty pall, wrap-around
   // arithmetic, the most negative quotient, character range limits and the undecoded op codes.
   task automatic test_error_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_instr(OP_POP, $urandom());
      send_instr(OP_PINT, $urandom());
      send_instr(OP_PUT_CHAR, $urandom());
      send_instr(OP_PALL, $urandom());
      send_instr(OP_ADD, $urandom());
      send_instr(OP_PUSH, WORD_MIN);
      send_instr(OP_SWAP, $urandom());
      send_instr(OP_PUSH, WORD_NEG_ONE);
      send_instr(OP_DIV, $urandom());
      send_instr(OP_PUSH, WORD_NEG_ONE);
      send_instr(OP_MOD, $urandom());
      send_instr(OP_PUSH, '0);
      send_instr(OP_DIV, $urandom());
      send_instr(OP_MOD, $urandom());
      send_instr(OP_POP, $urandom());
      send_instr(OP_PUSH, WORD_MAX);
      send_instr(OP_ADD, $urandom());
      send_instr(OP_PUSH, 32'd2);
      send_instr(OP_MUL, $urandom());
      send_instr(OP_PUT_CHAR, $urandom());
      send_instr(OP_PUSH, 32'd255);
      send_instr(OP_PUT_CHAR, $urandom());
      send_instr(OP_PUSH, -32'sd7);
      send_instr(OP_SUB, $urandom());
      send_instr(OP_PUT_CHAR, $urandom());
      send_instr(OP_SWAP, $urandom());
      send_instr(OP_PINT, $urandom());
      send_instr(OP_UNUSED_LAST, $urandom());
      send_instr(OP_UNUSED_FIRST, $urandom());
      send_instr(OP_NOP, $urandom());
      send_instr(OP_PALL, $urandom());
      drain_results();
   endtask

   // Fills the stack, pushes once more into a full stack and dumps it whole.
   task automatic test_stack_limits();
      send_idle_pct = 34;
      rsp_stall_pct = 34;
      while (stack_len < SME_STACK_DEPTH) begin
         send_instr(OP_PUSH, pick_operand());
         drain_results();
      end
      send_instr(OP_PUSH, pick_operand());
      send_instr(OP_PALL, $urandom());
      send_instr(OP_PINT, $urandom());
      drain_results();
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
      logic [SME_OP_W-1:0] op;
      int sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      gen_depth = stack_len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 4) begin
            // A burst of pushes drives the stack toward its full state.
            repeat ($urandom_range(40, 8)) begin
               send_instr(OP_PUSH, pick_operand());
               note_depth(OP_PUSH);
               sent++;
            end
         end else begin
            op = pick_op(gen_depth);
            send_instr(op, (op == OP_PUSH) ? pick_operand() : $urandom());
            note_depth(op);
            if (op < OP_NOP) sent++;
         end
      end
      drain_results();
   endtask

   // The receiver holds off for a long stretch while pints keep coming, so the
   // output register fills and the block must stop taking requests.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req_id++;
      repeat (12) begin
         send_instr(OP_PUSH, pick_operand());
         send_instr(OP_PINT, $urandom());
      end
      drain_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_error_cases();
      test_stack_limits();
      run_random_phase(0, 0, 50);
      run_random_phase(75, 0, 50);
      run_random_phase(0, 75, 50);
      run_random_phase(34, 34, 50);
      test_output_backpressure();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
